// ----- sv/pwh_pkg.sv -----
// Pulse width histogram: shared constants, codes and item types.
// No dependencies; every other file but pwh_ram takes names from here by scope.
package pwh_pkg;

    localparam int HIST_BINS  = 1024;
    localparam int LONG_SLOTS = 64;

    localparam int HIST_W   = $clog2(HIST_BINS);
    localparam int BIN_AW   = $clog2(2 * HIST_BINS);
    localparam int BIN_DEPTH = 2 * HIST_BINS;
    localparam int LONG_AW  = (LONG_SLOTS > 1) ? $clog2(LONG_SLOTS) : 1;
    localparam int FILL_W   = $clog2(LONG_SLOTS + 1);

    localparam logic [15:0] BIN_MAX  = 16'hFFFF;
    localparam logic [7:0]  MARK_MAX = 8'hFF;

    localparam int CFG_AW = 3;
    localparam logic REG_INVERT     = 1'b0;
    localparam logic REG_MARK_LIMIT = 1'b1;
    localparam logic [7:0] MARK_LIMIT_RST = 8'd4;

    typedef enum logic [1:0] {
        MODE_ARM       = 2'd0,
        MODE_EDGE      = 2'd1,
        MODE_READ_BIN  = 2'd2,
        MODE_READ_LONG = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } t_state;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] time_us;
        logic        level;
        logic [9:0]  index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] hist_count;
        logic        long_level;
        logic [30:0] long_width;
        logic [31:0] edge_count;
        logic [6:0]  long_count;
        logic [31:0] long_overflow;
        logic [31:0] span_us;
        logic [7:0]  mark_count;
        logic        armed;
        logic        done_res;
    } t_out_item;

endpackage

// ----- sv/pwh_if.sv -----
// Valid/ready channel interfaces for input and result items.
// Depends on pwh_pkg for the payload structs.
interface pwh_in_if;
    logic              valid;
    logic              ready;
    pwh_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pwh_out_if;
    logic               valid;
    logic               ready;
    pwh_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/pwh_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Standalone; used for the bin store and the long interval list.
module pwh_ram #(
    parameter int DW    = 16,
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/pulse_width_histogram.sv -----
// Pulse width histogram, top level: control, status registers, APB registers.
// Depends on pwh_pkg, pwh_if (channel interfaces) and pwh_ram.
//
//  channel   dir   handshake      payload
//  i_in      in    valid/ready    mode, time_us, level, index
//  o_out     out   valid/ready    hist_count .. done_res (one item per input)
//  apb       in    psel/penable   invert_input (0x0), mark_limit (0x4)
//
// Each item passes through accept (memory read issued) and execute (bin
// read-modify-write, status update, result loaded into the output register).
// The bin memory read is registered; no item is accepted until execute ends.
// Reset and every arm item start a clearing sweep of all 2*HIST_BINS (2048)
// bin memory entries, during which no item is accepted.
// A result stalled at o_out holds the block in execute; nothing is lost.
module pulse_width_histogram (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pwh_in_if.sink                     i_in,
    pwh_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pwh_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    pwh_pkg::t_state r_state, n_state;
    logic [pwh_pkg::BIN_AW-1:0] r_clr, n_clr;

    // configuration
    logic       r_invert;
    logic [7:0] r_limit;

    // capture status
    logic [pwh_pkg::FILL_W-1:0] r_fill, n_fill;
    logic [31:0] r_drop, n_drop;
    logic [7:0]  r_marks, n_marks;
    logic [31:0] r_prev_time, n_prev_time;
    logic        r_prev_level, n_prev_level;
    logic        r_have_prev, n_have_prev;
    logic [31:0] r_edges, n_edges;
    logic [31:0] r_first, n_first;
    logic        r_armed, n_armed;

    // item in flight
    pwh_pkg::t_in_item          r_item;
    logic [31:0]                r_width;
    logic                       r_short;
    logic [pwh_pkg::BIN_AW-1:0] r_bin_addr;

    // output register
    pwh_pkg::t_out_item r_out, n_out;
    logic               r_out_valid;

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    logic                        bin_we, bin_re;
    logic [pwh_pkg::BIN_AW-1:0]  bin_waddr, bin_raddr;
    logic [15:0]                 bin_wdata, bin_q;
    logic                        long_we, long_re;
    logic [pwh_pkg::LONG_AW-1:0] long_waddr, long_raddr;
    logic [31:0]                 long_wdata, long_q;

    pwh_ram #(
        .DW    (16),
        .DEPTH (pwh_pkg::BIN_DEPTH),
        .AW    (pwh_pkg::BIN_AW)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (bin_waddr),
        .i_wdata (bin_wdata),
        .i_re    (bin_re),
        .i_raddr (bin_raddr),
        .o_rdata (bin_q)
    );

    pwh_ram #(
        .DW    (32),
        .DEPTH (pwh_pkg::LONG_SLOTS),
        .AW    (pwh_pkg::LONG_AW)
    ) u_long_ram (
        .i_clk   (i_clk),
        .i_we    (long_we),
        .i_waddr (long_waddr),
        .i_wdata (long_wdata),
        .i_re    (long_re),
        .i_raddr (long_raddr),
        .o_rdata (long_q)
    );

    // ---------------------------------------------------------------
    // Handshake qualifiers
    // ---------------------------------------------------------------
    logic in_fire, exec_go, clr_last;

    assign in_fire  = i_in.valid && (r_state == pwh_pkg::ST_IDLE);
    // execute completes once the output register is free or being drained
    assign exec_go  = (r_state == pwh_pkg::ST_EXEC) && (!r_out_valid || o_out.ready);
    assign clr_last = (r_clr == pwh_pkg::BIN_AW'(pwh_pkg::BIN_DEPTH - 1));

    // ---------------------------------------------------------------
    // Accept stage: interval and memory addresses
    // ---------------------------------------------------------------
    logic [31:0]                acc_width;
    logic                       acc_short;
    logic [pwh_pkg::BIN_AW-1:0] acc_edge_addr, acc_read_addr;

    always_comb begin
        acc_width = i_in.data.time_us - r_prev_time;
        acc_short = (acc_width < 32'(pwh_pkg::HIST_BINS));
        // bin of level l is entry l*HIST_BINS + b
        acc_edge_addr = pwh_pkg::BIN_AW'(acc_width[pwh_pkg::HIST_W-1:0])
                      + (r_prev_level ? pwh_pkg::BIN_AW'(pwh_pkg::HIST_BINS)
                                      : pwh_pkg::BIN_AW'(0));
        acc_read_addr = pwh_pkg::BIN_AW'(pwh_pkg::HIST_W'(i_in.data.index))
                      + (i_in.data.level ? pwh_pkg::BIN_AW'(pwh_pkg::HIST_BINS)
                                         : pwh_pkg::BIN_AW'(0));
    end

    // ---------------------------------------------------------------
    // Execute stage: next status, memory write-back, result
    // ---------------------------------------------------------------
    logic [7:0]  limit_eff;
    logic        bin_upd, long_upd;
    logic [15:0] hist_val;
    logic        llev;
    logic [30:0] lwid;

    always_comb begin
        n_fill       = r_fill;
        n_drop       = r_drop;
        n_marks      = r_marks;
        n_prev_time  = r_prev_time;
        n_prev_level = r_prev_level;
        n_have_prev  = r_have_prev;
        n_edges      = r_edges;
        n_first      = r_first;
        n_armed      = r_armed;
        bin_upd      = 1'b0;
        long_upd     = 1'b0;
        hist_val     = '0;
        llev         = 1'b0;
        lwid         = '0;
        limit_eff    = (r_limit == 8'd0) ? 8'd1 : r_limit;

        case (r_item.mode)
            pwh_pkg::MODE_ARM: begin
                n_fill       = '0;
                n_drop       = '0;
                n_marks      = '0;
                n_prev_time  = '0;
                n_prev_level = 1'b0;
                n_have_prev  = 1'b0;
                n_edges      = '0;
                n_first      = '0;
                n_armed      = 1'b1;
            end
            pwh_pkg::MODE_EDGE: begin
                if (r_armed) begin
                    if (r_have_prev) begin
                        if (r_short) begin
                            bin_upd = 1'b1;
                        end else begin
                            if (r_prev_level && (r_marks != pwh_pkg::MARK_MAX)) begin
                                n_marks = r_marks + 8'd1;
                            end
                            if (32'(r_fill) < 32'(pwh_pkg::LONG_SLOTS)) begin
                                long_upd = 1'b1;
                                n_fill   = r_fill + pwh_pkg::FILL_W'(1);
                            end else begin
                                n_drop = r_drop + 32'd1;
                            end
                        end
                    end else begin
                        n_first = r_item.time_us;
                    end
                    n_prev_time  = r_item.time_us;
                    n_prev_level = r_item.level ^ r_invert;
                    n_have_prev  = 1'b1;
                    n_edges      = r_edges + 32'd1;
                    if (n_marks >= limit_eff) begin
                        n_armed = 1'b0;
                    end
                end
            end
            pwh_pkg::MODE_READ_BIN: begin
                if (32'(r_item.index) < 32'(pwh_pkg::HIST_BINS)) begin
                    hist_val = bin_q;
                end
            end
            pwh_pkg::MODE_READ_LONG: begin
                // slots at or past the fill point read as zero
                if ((32'(r_item.index) < 32'(r_fill)) &&
                    (32'(r_item.index) < 32'(pwh_pkg::LONG_SLOTS))) begin
                    llev = long_q[31];
                    lwid = long_q[30:0];
                end
            end
            default: begin
            end
        endcase

        n_out.hist_count    = hist_val;
        n_out.long_level    = llev;
        n_out.long_width    = lwid;
        n_out.edge_count    = n_edges;
        n_out.long_count    = 7'(n_fill);
        n_out.long_overflow = n_drop;
        n_out.span_us       = (n_edges >= 32'd2) ? (n_prev_time - n_first) : 32'd0;
        n_out.mark_count    = n_marks;
        n_out.armed         = n_armed;
        n_out.done_res      = (n_marks >= limit_eff);
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            pwh_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    n_state = pwh_pkg::ST_IDLE;
                    n_clr   = '0;
                end else begin
                    n_clr = r_clr + pwh_pkg::BIN_AW'(1);
                end
            end
            pwh_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = pwh_pkg::ST_EXEC;
                end
            end
            pwh_pkg::ST_EXEC: begin
                if (exec_go) begin
                    n_state = (r_item.mode == pwh_pkg::MODE_ARM) ? pwh_pkg::ST_CLEAR
                                                                 : pwh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pwh_pkg::ST_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs (handshake and memory ports)
    // ---------------------------------------------------------------
    always_comb begin
        i_in.ready = (r_state == pwh_pkg::ST_IDLE);

        bin_re    = in_fire && ((i_in.data.mode == pwh_pkg::MODE_EDGE) ||
                                (i_in.data.mode == pwh_pkg::MODE_READ_BIN));
        bin_raddr = (i_in.data.mode == pwh_pkg::MODE_EDGE) ? acc_edge_addr
                                                           : acc_read_addr;
        if (r_state == pwh_pkg::ST_CLEAR) begin
            bin_we    = 1'b1;
            bin_waddr = r_clr;
            bin_wdata = '0;
        end else begin
            bin_we    = exec_go && bin_upd;
            bin_waddr = r_bin_addr;
            bin_wdata = (bin_q == pwh_pkg::BIN_MAX) ? bin_q : (bin_q + 16'd1);
        end

        long_re    = in_fire && (i_in.data.mode == pwh_pkg::MODE_READ_LONG);
        long_raddr = pwh_pkg::LONG_AW'(i_in.data.index);
        long_we    = exec_go && long_upd;
        long_waddr = r_fill[pwh_pkg::LONG_AW-1:0];
        long_wdata = {r_prev_level, r_width[30:0]};
    end

    // ---------------------------------------------------------------
    // Control and status registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pwh_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_fill       <= '0;
            r_drop       <= '0;
            r_marks      <= '0;
            r_prev_time  <= '0;
            r_prev_level <= 1'b0;
            r_have_prev  <= 1'b0;
            r_edges      <= '0;
            r_first      <= '0;
            r_armed      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (exec_go) begin
                r_fill       <= n_fill;
                r_drop       <= n_drop;
                r_marks      <= n_marks;
                r_prev_time  <= n_prev_time;
                r_prev_level <= n_prev_level;
                r_have_prev  <= n_have_prev;
                r_edges      <= n_edges;
                r_first      <= n_first;
                r_armed      <= n_armed;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item     <= i_in.data;
            r_width    <= acc_width;
            r_short    <= acc_short;
            r_bin_addr <= acc_edge_addr;
        end
        if (exec_go) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // ---------------------------------------------------------------
    // APB registers
    // ---------------------------------------------------------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b0;
            r_limit  <= pwh_pkg::MARK_LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                pwh_pkg::REG_INVERT:     r_invert <= pwdata[0];
                pwh_pkg::REG_MARK_LIMIT: r_limit  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            pwh_pkg::REG_INVERT:     prdata = {31'd0, r_invert};
            pwh_pkg::REG_MARK_LIMIT: prdata = {24'd0, r_limit};
            default:                 prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // list fill never runs past the number of slots
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(pwh_pkg::LONG_SLOTS))
        else $error("long list fill past slot count");

    // a new result only appears right after an execute cycle
    a_out_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == pwh_pkg::ST_EXEC))
        else $error("result without execute");

    // the clearing sweep steps by one entry each cycle until it ends
    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && (r_state == pwh_pkg::ST_CLEAR) && !clr_last |=>
            (r_state == pwh_pkg::ST_CLEAR) &&
            (r_clr == $past(r_clr) + pwh_pkg::BIN_AW'(1)))
        else $error("clearing sweep skipped or stalled");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for pulse_width_histogram: directed items, back-pressure,
// a full long-interval capture and random traffic under four idling phases.
// Needs pwh_pkg, the pwh_if channel interfaces and the block's RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          TAIL_CYCLES = 50;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [pwh_pkg::CFG_AW-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    pwh_in_if  in_ch ();
    pwh_out_if out_ch ();

    pulse_width_histogram i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the capture state, updated once per accepted item
    // ------------------------------------------------------------------
    logic [15:0] bin_mem [0:pwh_pkg::BIN_DEPTH-1];
    logic [31:0] long_mem [0:pwh_pkg::LONG_SLOTS-1];
    logic [6:0]  fill_r;
    logic [31:0] drops_r;
    logic [7:0]  marks_r;
    logic [31:0] last_t;
    logic        last_lvl;
    logic        seen_edge;
    logic [31:0] edge_n;
    logic [31:0] start_t;
    logic        capturing;
    logic        invert_r;
    logic [7:0]  limit_r;

    pwh_pkg::t_out_item pulse_results [$];   // status items still owed by the block

    // stimulus bookkeeping
    logic [31:0] stim_t;
    logic        stim_lvl;
    logic [9:0]  last_short;
    int          send_idle_pct;
    int          sink_stall_pct;
    logic        hold_on;
    event        hold_go;

    int          error_n   = 0;   // result side
    int          cfg_err_n = 0;   // register readback
    int          sent_n;
    int          arm_n;
    int          edge_sent_n;
    int          checked_n = 0;
    int          peak_marks;
    int          peak_drops;
    int unsigned cycle_n   = 0;

    function automatic void wipe_capture();
        for (int b = 0; b < pwh_pkg::BIN_DEPTH; b++) bin_mem[b] = 16'd0;
        for (int s = 0; s < pwh_pkg::LONG_SLOTS; s++) long_mem[s] = 32'd0;
        fill_r    = '0;
        drops_r   = '0;
        marks_r   = '0;
        last_t    = '0;
        last_lvl  = 1'b0;
        seen_edge = 1'b0;
        edge_n    = '0;
        start_t   = '0;
    endfunction

    // Applies one item to the shadow state and returns the status it yields.
    function automatic pwh_pkg::t_out_item track_pulse_item(input pwh_pkg::t_in_item it);
        pwh_pkg::t_out_item r;
        logic [31:0]        width;
        logic [7:0]         lim;
        int                 slot;
        r = '0;
        lim = (limit_r == 8'd0) ? 8'd1 : limit_r;   // zero limit acts as one
        case (it.mode)
            pwh_pkg::MODE_ARM: begin
                wipe_capture();
                capturing = 1'b1;
            end
            pwh_pkg::MODE_EDGE: begin
                if (capturing) begin
                    if (seen_edge) begin
                        width = it.time_us - last_t;   // wraps with the timestamp
                        if (width < pwh_pkg::HIST_BINS) begin
                            slot = int'(last_lvl) * pwh_pkg::HIST_BINS + int'(width);
                            if (bin_mem[slot] != pwh_pkg::BIN_MAX)
                                bin_mem[slot] = bin_mem[slot] + 16'd1;
                        end else begin
                            if (last_lvl && marks_r != pwh_pkg::MARK_MAX)
                                marks_r = marks_r + 8'd1;
                            if (fill_r < pwh_pkg::LONG_SLOTS) begin
                                long_mem[fill_r] = {last_lvl, width[30:0]};
                                fill_r = fill_r + 7'd1;
                            end else begin
                                drops_r = drops_r + 32'd1;
                            end
                        end
                    end else begin
                        start_t = it.time_us;
                    end
                    last_t    = it.time_us;
                    last_lvl  = it.level ^ invert_r;
                    seen_edge = 1'b1;
                    edge_n    = edge_n + 32'd1;
                    // the edge that reaches the limit is still filed in full
                    if (marks_r >= lim) capturing = 1'b0;
                end
            end
            pwh_pkg::MODE_READ_BIN: begin
                if (it.index < pwh_pkg::HIST_BINS)
                    r.hist_count = bin_mem[int'(it.level) * pwh_pkg::HIST_BINS
                                           + int'(it.index)];
            end
            default: begin
                if (it.index < fill_r && it.index < pwh_pkg::LONG_SLOTS) begin
                    r.long_level = long_mem[it.index][31];
                    r.long_width = long_mem[it.index][30:0];
                end
            end
        endcase
        r.edge_count    = edge_n;
        r.long_count    = fill_r;
        r.long_overflow = drops_r;
        r.span_us       = (edge_n >= 32'd2) ? (last_t - start_t) : 32'd0;
        r.mark_count    = marks_r;
        r.armed         = capturing;
        r.done_res      = (marks_r >= lim);
        return r;
    endfunction

    // Returns 1 on a mismatch, after reporting it.
    function automatic int check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Result side: compare, then pick ready for the next cycle
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        pwh_pkg::t_out_item want;
        pwh_pkg::t_out_item got;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (pulse_results.size() == 0) begin
                    $error("status item arrived with nothing pending");
                    error_n++;
                end else begin
                    want = pulse_results.pop_front();
                    error_n += check_field("hist_count", 32'(want.hist_count),
                                           32'(got.hist_count));
                    error_n += check_field("long_level", 32'(want.long_level),
                                           32'(got.long_level));
                    error_n += check_field("long_width", 32'(want.long_width),
                                           32'(got.long_width));
                    error_n += check_field("edge_count", want.edge_count, got.edge_count);
                    error_n += check_field("long_count", 32'(want.long_count),
                                           32'(got.long_count));
                    error_n += check_field("long_overflow", want.long_overflow,
                                           got.long_overflow);
                    error_n += check_field("span_us", want.span_us, got.span_us);
                    error_n += check_field("mark_count", 32'(want.mark_count),
                                           32'(got.mark_count));
                    error_n += check_field("armed", 32'(want.armed), 32'(got.armed));
                    error_n += check_field("done_res", 32'(want.done_res),
                                           32'(got.done_res));
                    checked_n++;
                end
            end
            out_ch.ready <= !hold_on && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
    initial begin
        hold_on <= 1'b0;
        forever begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_on <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d items pending", cycle_n, pulse_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic apb_xfer(input logic wr, input logic [pwh_pkg::CFG_AW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a register, read it back, and move the shadow copy along.
    task automatic set_register(input logic reg_sel, input logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] keep;
        keep = (reg_sel == pwh_pkg::REG_INVERT) ? 32'h1 : 32'hFF;
        apb_xfer(1'b1, {reg_sel, 2'b00}, value, rd);
        apb_xfer(1'b0, {reg_sel, 2'b00}, 32'h0, rd);
        cfg_err_n += check_field("prdata", value & keep, rd & keep);
        if (reg_sel == pwh_pkg::REG_INVERT) invert_r = value[0];
        else limit_r = value[7:0];
    endtask

    task automatic send_item(input pwh_pkg::t_mode m, input logic [31:0] t,
                             input logic lvl, input logic [9:0] idx);
        pwh_pkg::t_in_item it;
        it.mode    = m;
        it.time_us = t;
        it.level   = lvl;
        it.index   = idx;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pulse_results.push_back(track_pulse_item(it));
        sent_n++;
        if (m == pwh_pkg::MODE_ARM) arm_n++;
        if (m == pwh_pkg::MODE_EDGE) edge_sent_n++;
        if (int'(marks_r) > peak_marks) peak_marks = int'(marks_r);
        if (int'(drops_r) > peak_drops) peak_drops = int'(drops_r);
    endtask

    task automatic edge_at(input logic [31:0] delta, input logic lvl);
        stim_t = stim_t + delta;
        send_item(pwh_pkg::MODE_EDGE, stim_t, lvl, 10'($urandom));
    endtask

    // Let every owed status item drain before touching registers or pacing.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pulse_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly armed, alternating edges with bins and long slots read back; some noise.
    task automatic random_item();
        int          pick;
        logic [31:0] delta;
        logic [9:0]  idx;
        pick = $urandom_range(99);
        if (!capturing && $urandom_range(99) < 30) pick = 0;   // re-arm after a capture ends
        if (pick < 3) begin
            send_item(pwh_pkg::MODE_ARM, $urandom, 1'($urandom), 10'($urandom));
        end else if (pick < 63) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5, 6: begin
                    delta = $urandom_range(1) ? $urandom_range(7)
                                              : $urandom_range(pwh_pkg::HIST_BINS - 1);
                    last_short = delta[9:0];
                end
                7, 8:    delta = $urandom_range(200000, pwh_pkg::HIST_BINS);
                default: delta = $urandom;
            endcase
            stim_lvl = ($urandom_range(9) < 8) ? ~stim_lvl : 1'($urandom);
            edge_at(delta, stim_lvl);
        end else if (pick < 83) begin
            idx = $urandom_range(3) != 0 ? last_short : 10'($urandom);
            send_item(pwh_pkg::MODE_READ_BIN, $urandom, 1'($urandom), idx);
        end else if (pick < 95) begin
            idx = $urandom_range(3) != 0 ? 10'($urandom_range(int'(fill_r) + 1)) : 10'($urandom);
            send_item(pwh_pkg::MODE_READ_LONG, $urandom, 1'($urandom), idx);
        end else begin
            send_item(pwh_pkg::t_mode'($urandom_range(3)), $urandom, 1'($urandom),
                      10'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        set_register(pwh_pkg::REG_INVERT, 32'h0);
        set_register(pwh_pkg::REG_MARK_LIMIT, 32'd2);
        // edge before any arm is ignored, reads still report status
        send_item(pwh_pkg::MODE_EDGE, 32'd100, 1'b1, 10'd0);
        send_item(pwh_pkg::MODE_READ_BIN, 32'hFFFF_FFFF, 1'b0, 10'd0);
        send_item(pwh_pkg::MODE_ARM, 32'hFFFF_FFFF, 1'b1, 10'h3FF);
        stim_t = 32'hFFFF_FFF0;
        edge_at(32'd0, 1'b1);                   // first edge: no interval, span zero
        edge_at(32'h1A, 1'b0);                  // short high across the timestamp wrap
        edge_at(32'd0, 1'b1);                   // zero-width low
        edge_at(pwh_pkg::HIST_BINS - 1, 1'b0);  // widest short high
        edge_at(pwh_pkg::HIST_BINS, 1'b1);      // narrowest long low
        edge_at(32'h8000_0005, 1'b0);           // long high, bit 31 of width lost; first mark
        send_item(pwh_pkg::MODE_READ_BIN, $urandom, 1'b1, 10'd26);
        send_item(pwh_pkg::MODE_READ_BIN, $urandom, 1'b1, 10'h3FF);
        send_item(pwh_pkg::MODE_READ_BIN, $urandom, 1'b0, 10'd0);
        send_item(pwh_pkg::MODE_READ_LONG, $urandom, 1'($urandom), 10'd0);
        send_item(pwh_pkg::MODE_READ_LONG, $urandom, 1'($urandom), 10'd1);
        send_item(pwh_pkg::MODE_READ_LONG, $urandom, 1'($urandom), 10'd2);    // past the fill
        send_item(pwh_pkg::MODE_READ_LONG, $urandom, 1'($urandom), 10'h3FF);
        edge_at(32'd5000, 1'b1);            // long low
        edge_at(32'd3000, 1'b0);            // long high reaches the limit, capture stops
        edge_at(32'd10, 1'b1);              // disarmed: ignored
        send_item(pwh_pkg::MODE_READ_LONG, $urandom, 1'($urandom), 10'd3);
        wait_idle();
        // inverted input and a zero limit, upper write bits set
        set_register(pwh_pkg::REG_INVERT, 32'hFFFF_FFFF);
        set_register(pwh_pkg::REG_MARK_LIMIT, 32'hFFFF_FF00);
        send_item(pwh_pkg::MODE_ARM, 32'd0, 1'b0, 10'd0);
        edge_at(32'd7, 1'b0);               // raw low filed as high
        edge_at(32'd1500, 1'b1);            // one mark ends it
        edge_at(32'd1, 1'b0);
        send_item(pwh_pkg::MODE_READ_LONG, $urandom, 1'($urandom), 10'd0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        set_register(pwh_pkg::REG_MARK_LIMIT, 32'd255);
        send_item(pwh_pkg::MODE_ARM, $urandom, 1'($urandom), 10'($urandom));
        -> hold_go;
        repeat (40) random_item();
        wait_idle();
    endtask

    // Fill the long list, overflow it and run the marks up to 255.
    task automatic test_long_list();
        send_idle_pct  = 7;
        sink_stall_pct = 7;
        set_register(pwh_pkg::REG_INVERT, 32'h1);
        set_register(pwh_pkg::REG_MARK_LIMIT, 32'd255);
        send_item(pwh_pkg::MODE_ARM, $urandom, 1'($urandom), 10'($urandom));
        edge_at($urandom, ~invert_r);
        while (capturing) begin
            edge_at($urandom_range(1 << 20, pwh_pkg::HIST_BINS), invert_r);
            edge_at($urandom_range(1) ? $urandom_range(pwh_pkg::HIST_BINS - 1) : $urandom,
                    ~invert_r);
            if ($urandom_range(7) == 0)
                send_item(pwh_pkg::MODE_READ_LONG, $urandom, 1'($urandom),
                          10'($urandom_range(pwh_pkg::LONG_SLOTS + 3)));
        end
        edge_at(32'd100, invert_r);
        for (int n = 0; n < 8; n++)
            send_item(pwh_pkg::MODE_READ_LONG, $urandom, 1'($urandom),
                      10'(pwh_pkg::LONG_SLOTS - 4 + n));
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 73; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 73; end
                default: begin send_idle_pct = 7; sink_stall_pct = 7; end
            endcase
            set_register(pwh_pkg::REG_INVERT,
                         {31'($urandom_range(32'h7FFF_FFFF)), 1'(ph)});
            case (ph)
                0: set_register(pwh_pkg::REG_MARK_LIMIT, 32'd255);
                1: set_register(pwh_pkg::REG_MARK_LIMIT, 32'd1);
                2: set_register(pwh_pkg::REG_MARK_LIMIT, $urandom_range(12, 2));
                default: set_register(pwh_pkg::REG_MARK_LIMIT, $urandom_range(255, 1));
            endcase
            send_item(pwh_pkg::MODE_ARM, $urandom, 1'($urandom), 10'($urandom));
            stim_t = $urandom;
            repeat (170) random_item();
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    initial begin
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.data    <= '0;
        i_rst_n       <= 1'b0;
        sent_n         = 0;
        arm_n          = 0;
        edge_sent_n    = 0;
        peak_marks     = 0;
        peak_drops     = 0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        stim_t         = '0;
        stim_lvl       = 1'b0;
        last_short     = '0;
        wipe_capture();
        capturing = 1'b0;
        invert_r  = 1'b0;
        limit_r   = pwh_pkg::MARK_LIMIT_RST;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_long_list();
        test_random_traffic();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run: %0d items (%0d arms, %0d edges), %0d status items checked",
                 sent_n, arm_n, edge_sent_n, checked_n);
        $display("Run: up to %0d marks in one capture, up to %0d long intervals dropped",
                 peak_marks, peak_drops);
        if (error_n == 0 && cfg_err_n == 0 && pulse_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
